// ----- hw/rtl/wavhp_pkg.sv -----
// Shared types and constants for the WAV header parser.
package wavhp_pkg;

    // Chunk and form tags, read as little-endian 32-bit words.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Parse phase codes.
    localparam logic [3:0] PH_RIFF   = 4'd0;
    localparam logic [3:0] PH_RSIZE  = 4'd1;
    localparam logic [3:0] PH_WAVE   = 4'd2;
    localparam logic [3:0] PH_CTAG   = 4'd3;
    localparam logic [3:0] PH_CSIZE  = 4'd4;
    localparam logic [3:0] PH_FTAG   = 4'd5;
    localparam logic [3:0] PH_FCH    = 4'd6;
    localparam logic [3:0] PH_FRATE  = 4'd7;
    localparam logic [3:0] PH_FBRATE = 4'd8;
    localparam logic [3:0] PH_FBLOCK = 4'd9;
    localparam logic [3:0] PH_FBITS  = 4'd10;
    localparam logic [3:0] PH_SKIP   = 4'd11;
    localparam logic [3:0] PH_DONE   = 4'd12;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_RIFF  = 3'd1;
    localparam logic [2:0] ST_NO_WAVE  = 3'd2;
    localparam logic [2:0] ST_NOT_PCM  = 3'd3;
    localparam logic [2:0] ST_BAD_CHAN = 3'd4;

    // PCM format tag and largest accepted channel count.
    localparam logic [31:0] PCM_TAG  = 32'd1;
    localparam logic [31:0] MAX_CHAN = 32'd2;

    // Format codes.
    localparam logic [1:0] FC_MONO8   = 2'd0;
    localparam logic [1:0] FC_STEREO8 = 2'd2;

    // One result word.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] sample_rate;
        logic [31:0] data_bytes;
        logic [31:0] data_offset;
        logic [1:0]  format_code;
    } wavhp_result_t;

endpackage

// ----- hw/rtl/wavhp_in_reg.sv -----
// Input register stage that holds one accepted byte word for the parser.
module wavhp_in_reg
    import wavhp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_stream_byte,
    input  logic       s_file_start,
    input  logic       take,
    output logic       hold_valid,
    output logic [7:0] hold_byte,
    output logic       hold_start
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;

    // The slot is free when empty or when the parser takes its word this cycle.
    assign s_ready = !valid_reg || take;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg  <= s_stream_byte;
            start_reg <= s_file_start;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;
    assign hold_start = start_reg;

endmodule

// ----- hw/rtl/wavhp_parse.sv -----
// Header parse state and the per-byte update logic.
module wavhp_parse
    import wavhp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          hold_valid,
    input  logic [7:0]    hold_byte,
    input  logic          hold_start,
    input  logic          out_free,
    output logic          take,
    output logic          res_valid,
    output wavhp_result_t res
);

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] ctag_reg, ctag_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] pos_reg, pos_next;
    logic [1:0]  seen_reg, seen_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] dsize_reg, dsize_next;
    logic [31:0] doffs_reg, doffs_next;
    logic        emit;
    logic [2:0]  emit_status;

    // Next state for one byte; a file start clears everything first.
    always_comb begin
        logic [3:0]  cur_phase;
        logic [2:0]  cur_idx;
        logic [31:0] cur_shift;
        logic [31:0] cur_pos;
        logic [31:0] word_new;
        logic [2:0]  idx_inc;
        logic        len4;
        logic        field_done;
        logic [31:0] v;

        cur_phase   = hold_start ? PH_RIFF : phase_reg;
        cur_idx     = hold_start ? 3'd0 : idx_reg;
        cur_shift   = hold_start ? 32'd0 : shift_reg;
        cur_pos     = hold_start ? 32'd0 : pos_reg;
        ctag_next   = hold_start ? 32'd0 : ctag_reg;
        remain_next = hold_start ? 32'd0 : remain_reg;
        seen_next   = hold_start ? 2'd0 : seen_reg;
        chan_next   = hold_start ? 16'd0 : chan_reg;
        bits_next   = hold_start ? 16'd0 : bits_reg;
        rate_next   = hold_start ? 32'd0 : rate_reg;
        dsize_next  = hold_start ? 32'd0 : dsize_reg;
        doffs_next  = hold_start ? 32'd0 : doffs_reg;

        phase_next  = cur_phase;
        idx_next    = cur_idx;
        shift_next  = cur_shift;
        pos_next    = cur_pos + 32'd1;
        emit        = 1'b0;
        emit_status = ST_OK;

        word_new   = {hold_byte, cur_shift[31:8]};
        idx_inc    = cur_idx + 3'd1;
        len4       = !(cur_phase == PH_FTAG || cur_phase == PH_FCH ||
                       cur_phase == PH_FBLOCK || cur_phase == PH_FBITS);
        field_done = len4 ? idx_inc[2] : (|idx_inc[2:1]);
        v          = len4 ? word_new : {16'd0, word_new[31:16]};

        unique case (cur_phase) inside
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            PH_SKIP: begin
                remain_next = remain_next - 32'd1;
                if (remain_next == 32'd0) begin
                    phase_next = PH_CTAG;
                end
            end
            [PH_RIFF:PH_FBITS]: begin
                shift_next = word_new;
                idx_next   = idx_inc;
                if (field_done) begin
                    idx_next = 3'd0;
                    unique case (cur_phase)
                        PH_RIFF: begin
                            if (v != TAG_RIFF) begin
                                emit        = 1'b1;
                                emit_status = ST_NO_RIFF;
                            end else begin
                                phase_next = PH_RSIZE;
                            end
                        end
                        PH_RSIZE: begin
                            phase_next = PH_WAVE;
                        end
                        PH_WAVE: begin
                            if (v != TAG_WAVE) begin
                                emit        = 1'b1;
                                emit_status = ST_NO_WAVE;
                            end else begin
                                phase_next = PH_CTAG;
                            end
                        end
                        PH_CTAG: begin
                            ctag_next  = v;
                            phase_next = PH_CSIZE;
                        end
                        PH_CSIZE: begin
                            if (ctag_next == TAG_FMT) begin
                                remain_next = (v >= 32'd16) ? v - 32'd16 : 32'd0;
                                phase_next  = PH_FTAG;
                            end else begin
                                if (ctag_next == TAG_DATA) begin
                                    dsize_next   = v;
                                    doffs_next   = cur_pos + 32'd1;
                                    seen_next[1] = 1'b1;
                                end
                                if (ctag_next == TAG_DATA && seen_next[0]) begin
                                    emit = 1'b1;
                                end else begin
                                    remain_next = v;
                                    phase_next  = (v != 32'd0) ? PH_SKIP : PH_CTAG;
                                end
                            end
                        end
                        PH_FTAG: begin
                            if (v != PCM_TAG) begin
                                emit        = 1'b1;
                                emit_status = ST_NOT_PCM;
                            end else begin
                                phase_next = PH_FCH;
                            end
                        end
                        PH_FCH: begin
                            chan_next = v[15:0];
                            if (v > MAX_CHAN) begin
                                emit        = 1'b1;
                                emit_status = ST_BAD_CHAN;
                            end else begin
                                phase_next = PH_FRATE;
                            end
                        end
                        PH_FRATE: begin
                            rate_next  = v;
                            phase_next = PH_FBRATE;
                        end
                        PH_FBRATE: begin
                            phase_next = PH_FBLOCK;
                        end
                        PH_FBLOCK: begin
                            phase_next = PH_FBITS;
                        end
                        default: begin
                            bits_next    = v[15:0];
                            seen_next[0] = 1'b1;
                            if (seen_next[1]) begin
                                emit = 1'b1;
                            end else begin
                                phase_next = (remain_next != 32'd0) ? PH_SKIP : PH_CTAG;
                            end
                        end
                    endcase
                    if (emit) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Result word built from the updated held values.
    always_comb begin
        logic eight_n;
        eight_n = (bits_next != 16'd8);
        res.status        = emit_status;
        res.channel_count = chan_next;
        res.sample_bits   = bits_next;
        res.sample_rate   = rate_next;
        res.data_bytes    = dsize_next;
        res.data_offset   = doffs_next;
        if (emit_status != ST_OK) begin
            res.format_code = FC_MONO8;
        end else if (chan_next == 16'd1) begin
            res.format_code = {1'b0, eight_n};
        end else begin
            res.format_code = FC_STEREO8 | {1'b0, eight_n};
        end
    end

    // A word without a result always moves; one with a result needs the output slot.
    assign res_valid = hold_valid && emit;
    assign take      = hold_valid && (out_free || !emit);

    // Parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_RIFF;
            idx_reg    <= 3'd0;
            shift_reg  <= 32'd0;
            ctag_reg   <= 32'd0;
            remain_reg <= 32'd0;
            pos_reg    <= 32'd0;
            seen_reg   <= 2'd0;
            chan_reg   <= 16'd0;
            bits_reg   <= 16'd0;
            rate_reg   <= 32'd0;
            dsize_reg  <= 32'd0;
            doffs_reg  <= 32'd0;
        end else if (take) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            shift_reg  <= shift_next;
            ctag_reg   <= ctag_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            seen_reg   <= seen_next;
            chan_reg   <= chan_next;
            bits_reg   <= bits_next;
            rate_reg   <= rate_next;
            dsize_reg  <= dsize_next;
            doffs_reg  <= doffs_next;
        end
    end

    // A delivered result parks the parser until the next file start.
    a_done_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        take && res_valid |=> phase_reg == PH_DONE)
        else $error("parser not parked after result");

    // No second result for a file.
    a_no_result_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid && !hold_start && phase_reg == PH_DONE |-> !res_valid)
        else $error("result emitted while parked");

    // The byte index never reaches the longest field length.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg[2] == 1'b0)
        else $error("field byte index out of range");

    // The file position advances by one for each byte taken within a file.
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !hold_start |=> pos_reg == $past(pos_reg) + 32'd1)
        else $error("file position did not advance");

endmodule

// ----- hw/rtl/wavhp_out_reg.sv -----
// Output register that holds one result word until the consumer takes it.
module wavhp_out_reg
    import wavhp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          res_valid,
    input  logic          take,
    input  wavhp_result_t res,
    output logic          out_free,
    output logic          m_valid,
    input  logic          m_ready,
    output wavhp_result_t m_res
);

    logic          valid_reg;
    wavhp_result_t data_reg;
    logic          load;

    assign out_free = !valid_reg || m_ready;
    assign load     = take && res_valid;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

endmodule

// ----- hw/rtl/wav_header_parser.sv -----
// Top level of the RIFF/WAVE PCM header parser.
//
//  Channel | Direction | Word                        | Handshake
//  s_      | in        | stream_byte, file_start     | s_valid / s_ready
//  m_      | out       | status, format and data info | m_valid / m_ready
//
// One byte word is taken per cycle unless a byte that makes a result finds the
// result register full; the parse is combinational, so a result word passes the
// input register and then the result register on its way from s_ to m_.
// The rate is set by the per-byte update of the parse state registers.
// Reset (aresetn low at a clock edge) parks both stages empty and starts a file.
// While a result waits on m_ready, bytes that make no result still flow; a byte
// that makes a second result stalls the input until the first one is taken.
module wav_header_parser
    import wavhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    input  logic        s_file_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_channel_count,
    output logic [15:0] m_sample_bits,
    output logic [31:0] m_sample_rate,
    output logic [31:0] m_data_bytes,
    output logic [31:0] m_data_offset,
    output logic [1:0]  m_format_code
);

    logic          hold_valid;
    logic [7:0]    hold_byte;
    logic          hold_start;
    logic          take;
    logic          out_free;
    logic          res_valid;
    wavhp_result_t res;
    wavhp_result_t m_res;

    // Input register.
    wavhp_in_reg u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .s_file_start  (s_file_start),
        .take          (take),
        .hold_valid    (hold_valid),
        .hold_byte     (hold_byte),
        .hold_start    (hold_start)
    );

    // Parse logic and header state.
    wavhp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte),
        .hold_start (hold_start),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register.
    wavhp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .take      (take),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_status        = m_res.status;
    assign m_channel_count = m_res.channel_count;
    assign m_sample_bits   = m_res.sample_bits;
    assign m_sample_rate   = m_res.sample_rate;
    assign m_data_bytes    = m_res.data_bytes;
    assign m_data_offset   = m_res.data_offset;
    assign m_format_code   = m_res.format_code;

endmodule

// ----- dv/wav_header_parser_test.sv -----
// Self-checking testbench for the WAV header parser: byte stream in, header words out.
`timescale 1ns / 100ps

module wav_header_parser_test
    import wavhp_pkg::*;
();

    localparam int ITEM_TARGET    = 1400;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    // Tracks the parse of the byte stream and holds the header words still owed.
    class header_scoreboard;
        logic [3:0]  phase;
        logic [2:0]  byte_idx;
        logic [31:0] shifter;
        logic [31:0] chunk_tag;
        logic [31:0] remaining;
        logic [31:0] position;
        logic [1:0]  seen;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] dsize;
        logic [31:0] doffset;
        wavhp_result_t expected_headers[$];
        int errors;
        int accepted_bytes;

        function new();
            restart();
            errors = 0;
            accepted_bytes = 0;
        endfunction

        function void restart();
            phase = PH_RIFF;
            byte_idx = 3'd0;
            shifter = 32'd0;
            chunk_tag = 32'd0;
            remaining = 32'd0;
            position = 32'd0;
            seen = 2'd0;
            chans = 16'd0;
            bits = 16'd0;
            rate = 32'd0;
            dsize = 32'd0;
            doffset = 32'd0;
        endfunction

        // Queue the header word for the current file and stop parsing it.
        function void close_file(logic [2:0] st);
            wavhp_result_t r;
            r.status = st;
            r.channel_count = chans;
            r.sample_bits = bits;
            r.sample_rate = rate;
            r.data_bytes = dsize;
            r.data_offset = doffset;
            r.format_code = FC_MONO8;
            if (st == ST_OK) begin
                r.format_code = (chans == 16'd1) ? FC_MONO8 : FC_STEREO8;
                r.format_code[0] = (bits != 16'd8);
            end
            expected_headers.push_back(r);
            phase = PH_DONE;
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            logic [31:0] pos;
            logic [31:0] v;
            int len;
            accepted_bytes++;
            if (start) restart();
            pos = position;
            position = pos + 32'd1;
            if (phase == PH_DONE) return;
            // Skipping a chunk body only counts bytes down.
            if (phase == PH_SKIP) begin
                remaining = remaining - 32'd1;
                if (remaining == 32'd0) phase = PH_CTAG;
                return;
            end
            if (phase > PH_SKIP) begin
                phase = PH_DONE;
                return;
            end
            // Little-endian field assembly, two or four bytes per field.
            shifter = {b, shifter[31:8]};
            byte_idx = byte_idx + 3'd1;
            len = (phase == PH_FTAG || phase == PH_FCH || phase == PH_FBLOCK ||
                   phase == PH_FBITS) ? 2 : 4;
            if (byte_idx < len) return;
            byte_idx = 3'd0;
            v = (len == 4) ? shifter : {16'd0, shifter[31:16]};
            case (phase)
                PH_RIFF: begin
                    if (v != TAG_RIFF) close_file(ST_NO_RIFF);
                    else phase = PH_RSIZE;
                end
                PH_RSIZE: phase = PH_WAVE;
                PH_WAVE: begin
                    if (v != TAG_WAVE) close_file(ST_NO_WAVE);
                    else phase = PH_CTAG;
                end
                PH_CTAG: begin
                    chunk_tag = v;
                    phase = PH_CSIZE;
                end
                PH_CSIZE: begin
                    if (chunk_tag == TAG_FMT) begin
                        remaining = (v >= 32'd16) ? v - 32'd16 : 32'd0;
                        phase = PH_FTAG;
                    end else begin
                        if (chunk_tag == TAG_DATA) begin
                            dsize = v;
                            doffset = pos + 32'd1;
                            seen[1] = 1'b1;
                        end
                        if (chunk_tag == TAG_DATA && seen[0]) begin
                            close_file(ST_OK);
                        end else begin
                            remaining = v;
                            phase = (v != 32'd0) ? PH_SKIP : PH_CTAG;
                        end
                    end
                end
                PH_FTAG: begin
                    if (v != PCM_TAG) close_file(ST_NOT_PCM);
                    else phase = PH_FCH;
                end
                PH_FCH: begin
                    chans = v[15:0];
                    if (v > MAX_CHAN) close_file(ST_BAD_CHAN);
                    else phase = PH_FRATE;
                end
                PH_FRATE: begin
                    rate = v;
                    phase = PH_FBRATE;
                end
                PH_FBRATE: phase = PH_FBLOCK;
                PH_FBLOCK: phase = PH_FBITS;
                default: begin
                    bits = v[15:0];
                    seen[0] = 1'b1;
                    if (seen[1]) close_file(ST_OK);
                    else phase = (remaining != 32'd0) ? PH_SKIP : PH_CTAG;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_header(wavhp_result_t got);
            wavhp_result_t want;
            if (expected_headers.size() == 0) begin
                errors++;
                $display("%0t: header word with none expected, status %0h", $time, got.status);
                return;
            end
            want = expected_headers.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("channel_count", want.channel_count, got.channel_count);
            compare_field("sample_bits", want.sample_bits, got.sample_bits);
            compare_field("sample_rate", want.sample_rate, got.sample_rate);
            compare_field("data_bytes", want.data_bytes, got.data_bytes);
            compare_field("data_offset", want.data_offset, got.data_offset);
            compare_field("format_code", want.format_code, got.format_code);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_stream_byte = 8'd0;
    logic        s_file_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_channel_count;
    logic [15:0] m_sample_bits;
    logic [31:0] m_sample_rate;
    logic [31:0] m_data_bytes;
    logic [31:0] m_data_offset;
    logic [1:0]  m_format_code;

    header_scoreboard sb = new();
    logic [7:0] wav_bytes[$];
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    bit rx_hold_req = 1'b0;
    int idle_cycles = 0;

    wav_header_parser uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stream_byte   (s_stream_byte),
        .s_file_start    (s_file_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_channel_count (m_channel_count),
        .m_sample_bits   (m_sample_bits),
        .m_sample_rate   (m_sample_rate),
        .m_data_bytes    (m_data_bytes),
        .m_data_offset   (m_data_offset),
        .m_format_code   (m_format_code)
    );

    always #10 aclk = ~aclk;

    // Observe both channels at the clock edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_stream_byte, s_file_start);
            if (m_valid && m_ready) begin
                sb.check_header({m_status, m_channel_count, m_sample_bits, m_sample_rate,
                                 m_data_bytes, m_data_offset, m_format_code});
            end
        end
    end

    // Stop the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    // Header word receiver with random stalls and one long hold-off on request.
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = draw_gap(recv_calm);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if ($urandom_range(0, 7) == 0) recv_calm = ~recv_calm;
        end
    end

    function automatic void push_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) wav_bytes.push_back(v[8*i +: 8]);
    endfunction

    // Build a RIFF/WAVE header into the byte buffer.
    function automatic void make_wav(logic [31:0] riff, logic [31:0] wave, logic [15:0] pcm,
                                     logic [15:0] chans, logic [31:0] rate, logic [15:0] bits,
                                     logic [31:0] fmt_size, logic [31:0] data_size,
                                     int early_data, int junk, int tail);
        int n;
        wav_bytes.delete();
        push_le(riff, 4);
        push_le($urandom, 4);
        push_le(wave, 4);
        // Unknown chunks are skipped by size.
        repeat (junk) begin
            n = $urandom_range(0, 8);
            push_le($urandom, 4);
            push_le(n, 4);
            repeat (n) push_le($urandom, 1);
        end
        // Data chunks ahead of fmt; the last one sets the held size and offset.
        for (int k = 0; k < early_data; k++) begin
            n = (k == early_data - 1) ? data_size : $urandom_range(0, 4);
            push_le(TAG_DATA, 4);
            push_le(n, 4);
            repeat (n) push_le($urandom, 1);
        end
        push_le(TAG_FMT, 4);
        push_le(fmt_size, 4);
        push_le(pcm, 2);
        push_le(chans, 2);
        push_le(rate, 4);
        push_le($urandom, 4);
        push_le($urandom, 2);
        push_le(bits, 2);
        if (fmt_size > 32'd16) repeat (fmt_size - 32'd16) push_le($urandom, 1);
        if (early_data == 0) begin
            push_le(TAG_DATA, 4);
            push_le(data_size, 4);
        end
        repeat (tail) push_le($urandom, 1);
    endfunction

    task automatic send_byte(logic [7:0] b, logic start);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_stream_byte <= b;
        s_file_start <= start;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_file(bit lead_start, int count, bit stray_starts);
        for (int i = 0; i < count; i++) begin
            send_byte(wav_bytes[i],
                      (i == 0) ? lead_start : (stray_starts && $urandom_range(0, 19) == 0));
        end
    endtask

    // Hold the input idle until every owed header word has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_headers.size() != 0);
    endtask

    // One random file: mostly well formed, some cut short, corrupted or pure noise.
    task automatic random_file();
        int kind;
        int early;
        int pick;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [15:0] pcm;
        logic [31:0] rate;
        logic [31:0] fsize;
        logic [31:0] dsize;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        chans = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(3, 65535))
                : 16'($urandom_range(1, 2));
        bits = ($urandom_range(0, 9) < 8) ? (($urandom_range(0, 1) != 0) ? 16'd16 : 16'd8)
               : 16'($urandom);
        pcm = ($urandom_range(0, 9) != 0) ? 16'd1 : 16'($urandom);
        rate = ($urandom_range(0, 1) != 0) ? $urandom_range(4000, 96000) : $urandom;
        pick = $urandom_range(0, 19);
        fsize = (pick < 14) ? 32'd16 : (pick < 17) ? $urandom_range(17, 40)
                : $urandom_range(0, 15);
        pick = $urandom_range(0, 19);
        early = (pick < 13) ? 0 : (pick < 18) ? 1 : 2;
        if (early != 0) dsize = $urandom_range(0, 12);
        else dsize = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 4096);
        make_wav(TAG_RIFF, TAG_WAVE, pcm, chans, rate, bits, fsize, dsize, early,
                 $urandom_range(0, 2), $urandom_range(0, 3));
        if ($urandom_range(0, 5) == 0) send_calm = ~send_calm;
        if (kind < 70) begin
            send_file(1'b1, wav_bytes.size(), 1'b0);
        end else if (kind < 80) begin
            send_file(1'b1, $urandom_range(1, wav_bytes.size() - 1), 1'b0);
        end else if (kind < 90) begin
            pick = $urandom_range(0, (wav_bytes.size() < 40) ? wav_bytes.size() - 1 : 39);
            wav_bytes[pick] = wav_bytes[pick] ^ (8'd1 << $urandom_range(0, 7));
            send_file(1'b1, wav_bytes.size(), 1'b0);
        end else begin
            wav_bytes.delete();
            if ($urandom_range(0, 1) != 0) push_le(TAG_RIFF, 4);
            repeat ($urandom_range(1, 36)) push_le($urandom, 1);
            send_file(1'b1, wav_bytes.size(), 1'b1);
        end
    endtask

    // Main sequence.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed files. The first one relies on reset alone to start the parse.
        make_wav(TAG_RIFF, TAG_WAVE, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd16, 32'd100, 0, 0, 0);
        send_file(1'b0, wav_bytes.size(), 1'b0);
        make_wav(TAG_RIFF ^ 32'h0100_0000, TAG_WAVE, 16'd1, 16'd1, 32'd8000, 16'd8,
                 32'd16, 32'd0, 0, 0, 0);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        make_wav(TAG_RIFF, 32'd0, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd16, 32'd0, 0, 0, 0);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        // Not PCM, then too many channels at both extremes.
        make_wav(TAG_RIFF, TAG_WAVE, 16'd3, 16'd2, 32'd44100, 16'd16, 32'd16, 32'd8, 0, 1, 0);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        make_wav(TAG_RIFF, TAG_WAVE, 16'd1, 16'd3, 32'd44100, 16'd16, 32'd16, 32'd8, 0, 0, 0);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        make_wav(TAG_RIFF, TAG_WAVE, 16'd1, 16'hFFFF, 32'd1, 16'd8, 32'd16, 32'd8, 0, 0, 0);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        // Zero channels count as stereo; all-ones field values.
        make_wav(TAG_RIFF, TAG_WAVE, 16'd1, 16'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd16,
                 32'hFFFF_FFFF, 0, 0, 2);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        // Short fmt chunk, then extra fmt bytes with an unknown chunk in front.
        make_wav(TAG_RIFF, TAG_WAVE, 16'd1, 16'd1, 32'd22050, 16'd16, 32'd0, 32'd4, 0, 0, 0);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        make_wav(TAG_RIFF, TAG_WAVE, 16'd1, 16'd2, 32'd11025, 16'd8, 32'd20, 32'd0, 0, 1, 0);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        // Data ahead of fmt: one chunk, then two with the second one held.
        make_wav(TAG_RIFF, TAG_WAVE, 16'd1, 16'd2, 32'd48000, 16'd16, 32'd16, 32'd5, 1, 0, 3);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        make_wav(TAG_RIFF, TAG_WAVE, 16'd1, 16'd1, 32'd0, 16'd0, 32'd18, 32'd0, 2, 0, 0);
        send_file(1'b1, wav_bytes.size(), 1'b0);

        // Hold the receiver off while short files pile up behind the result.
        wait_drained();
        rx_hold_req = 1'b1;
        repeat (12) begin
            make_wav(TAG_RIFF, $urandom, 16'd1, 16'd1, $urandom, 16'd8, 32'd16, 32'd0, 0, 0, 0);
            send_file(1'b1, ($urandom_range(0, 1) != 0) ? 12 : 4, 1'b0);
        end
        make_wav(TAG_RIFF, TAG_WAVE, 16'd1, 16'd2, 32'd32000, 16'd8, 32'd16, 32'd64, 0, 0, 1);
        send_file(1'b1, wav_bytes.size(), 1'b0);
        wait_drained();

        // Random files until about the planned number of byte words have gone in.
        while (sb.accepted_bytes < ITEM_TARGET) begin
            random_file();
            if ($urandom_range(0, 15) == 0) wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_headers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wavhp_pkg.sv
hw/rtl/wavhp_in_reg.sv
hw/rtl/wavhp_parse.sv
hw/rtl/wavhp_out_reg.sv
hw/rtl/wav_header_parser.sv
dv/wav_header_parser_test.sv
